@@ rtl/asp_pkg.sv @@
// ----------------------------------------------------------------------------
// asp_pkg
// shared types and constants for the smoothing, peak and tilt block
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int CORDIC_STEPS     = 24;
  localparam int ANGLE_SCALE_BITS = 20;
  localparam int CW               = 48;  // cordic datapath width

  localparam logic [0:0] REG_SMOOTH_ENABLE = 1'b0;
  localparam logic [0:0] REG_SMOOTH_WEIGHT = 1'b1;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd47185920;
      5'd1:  r = 32'd27855475;
      5'd2:  r = 32'd14718068;
      5'd3:  r = 32'd7471121;
      5'd4:  r = 32'd3750058;
      5'd5:  r = 32'd1876857;
      5'd6:  r = 32'd938658;
      5'd7:  r = 32'd469357;
      5'd8:  r = 32'd234682;
      5'd9:  r = 32'd117342;
      5'd10: r = 32'd58671;
      5'd11: r = 32'd29335;
      5'd12: r = 32'd14668;
      5'd13: r = 32'd7334;
      5'd14: r = 32'd3667;
      5'd15: r = 32'd1833;
      5'd16: r = 32'd917;
      5'd17: r = 32'd458;
      5'd18: r = 32'd229;
      5'd19: r = 32'd115;
      5'd20: r = 32'd57;
      5'd21: r = 32'd29;
      5'd22: r = 32'd14;
      5'd23: r = 32'd7;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // smoothed vector handed from front to back
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

endpackage

@@ rtl/asp_front.sv @@
// ----------------------------------------------------------------------------
// asp_front
// accepts samples and applies the exponential average, one axis a cycle
// ----------------------------------------------------------------------------
module asp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               smooth_enable,
  input  logic [16:0]        smooth_weight,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output asp_pkg::vec_t      out_vec
);
  import asp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state;
  logic [1:0] axis;
  logic have_previous;
  logic signed [15:0] samp [3];
  logic signed [15:0] last [3];
  logic signed [15:0] res [3];
  logic [16:0] w;
  logic signed [18:0] ws;
  logic signed [18:0] wp;
  logic signed [35:0] acc;
  logic signed [15:0] rounded;

  assign w  = (smooth_weight > 17'd65536) ? 17'd65536 : smooth_weight;
  assign ws = $signed({2'b00, w});
  assign wp = 19'sd65536 - ws;
  assign acc = 36'(ws) * 36'(samp[axis]) + 36'(wp) * 36'(last[axis]) + 36'sd32768;
  assign rounded = acc[31:16];

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_vec   = '{x: res[0], y: res[1], z: res[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      have_previous <= 1'b0;
      axis <= 2'd0;
      last[0] <= '0; last[1] <= '0; last[2] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            samp[0] <= in_x; samp[1] <= in_y; samp[2] <= in_z;
            axis <= 2'd0;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          res[axis] <= (smooth_enable && have_previous) ? rounded : samp[axis];
          last[axis] <= (smooth_enable && have_previous) ? rounded : samp[axis];
          if (axis == 2'd2) begin
            state <= S_OUT;
            have_previous <= 1'b1;
          end else begin
            axis <= axis + 2'd1;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/asp_fifo.sv @@
// ----------------------------------------------------------------------------
// asp_fifo
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module asp_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  asp_pkg::vec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output asp_pkg::vec_t out_data
);
  import asp_pkg::*;

  vec_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      count <= count + 2'((in_valid && in_ready) ? 1 : 0)
                     - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue overflow");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !out_valid) else $error("valid from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready)) |=> count == $past(count) + 2'd1)
    else $error("count did not rise");
`endif

endmodule

@@ rtl/asp_back.sv @@
// ----------------------------------------------------------------------------
// asp_back
// magnitude, peaks and cordic tilt angles on one shared sequencer
// ----------------------------------------------------------------------------
module asp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  asp_pkg::vec_t      in_vec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] smooth_x,
  output logic signed [15:0] smooth_y,
  output logic signed [15:0] smooth_z,
  output logic [15:0]        magnitude,
  output logic [14:0]        peak_x,
  output logic [14:0]        peak_y,
  output logic [14:0]        peak_z,
  output logic [15:0]        peak_magnitude,
  output logic signed [13:0] pitch_angle,
  output logic signed [14:0] roll_angle
);
  import asp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_PRE  = 3'd3;
  localparam logic [2:0] S_ROT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [1:0] sq_step;
  logic [5:0] cnt;
  logic       pass;   // 0 magnitude, 1 pitch denominator
  logic       angle;  // 0 pitch, 1 roll
  vec_t v;
  logic [31:0] yz2, xx;
  logic [47:0] rad, rem, root;
  logic signed [CW-1:0] cx, cy, cz;
  logic signed [15:0] max_x, max_y, max_z;
  logic [15:0] max_mag, mag;

  // square root step, two radicand bits per cycle
  logic [49:0] trial;
  logic [49:0] rem_sh;
  assign rem_sh = {rem, rad[47:46]};
  assign trial  = {root, 2'b01};

  // cordic step
  logic [4:0] ci;
  logic signed [CW-1:0] dx, dy;
  assign ci = cnt[4:0];
  assign dx = cy >>> ci;
  assign dy = cx >>> ci;

  // rounding and clamp of the angle
  logic signed [CW-1:0] rnd;
  logic signed [CW-1:0] lim;
  assign rnd = (cz + CW'(signed'(1 << 13))) >>> 14;
  assign lim = angle ? CW'(180 * 64) : CW'(90 * 64);

  logic signed [31:0] sq_in;
  logic [31:0] sq;
  always_comb begin
    case (sq_step)
      2'd0:    sq_in = 32'(v.x);
      2'd1:    sq_in = 32'(v.y);
      default: sq_in = 32'(v.z);
    endcase
  end
  assign sq = 32'(sq_in * sq_in);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign smooth_x = v.x;
  assign smooth_y = v.y;
  assign smooth_z = v.z;
  assign magnitude = mag;
  assign peak_x = max_x[14:0];
  assign peak_y = max_y[14:0];
  assign peak_z = max_z[14:0];
  assign peak_magnitude = max_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_x <= '0; max_y <= '0; max_z <= '0; max_mag <= '0;
      sq_step <= '0; cnt <= '0; pass <= 1'b0; angle <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            v <= in_vec;
            sq_step <= 2'd0;
            yz2 <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_step == 2'd0) xx <= sq;
          else yz2 <= yz2 + sq;
          if (sq_step == 2'd2) begin
            state <= S_SQRT;
            pass <= 1'b0;
            rad <= {16'd0, yz2 + sq + xx};
            rem <= '0; root <= '0; cnt <= '0;
          end
          sq_step <= sq_step + 2'd1;
          if (v.x > max_x) max_x <= v.x;
          if (v.y > max_y) max_y <= v.y;
          if (v.z > max_z) max_z <= v.z;
        end
        S_SQRT: begin
          if (rem_sh >= trial) begin
            rem  <= 48'(rem_sh - trial);
            root <= {root[46:0], 1'b1};
          end else begin
            rem  <= rem_sh[47:0];
            root <= {root[46:0], 1'b0};
          end
          rad <= {rad[45:0], 2'b00};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd23) begin
            if (!pass) begin
              mag <= (rem_sh >= trial) ? {root[14:0], 1'b1} : {root[14:0], 1'b0};
              pass <= 1'b1;
              rad <= {yz2, 16'd0};
              rem <= '0; root <= '0; cnt <= '0;
            end else begin
              angle <= 1'b0;
              cx <= CW'((rem_sh >= trial) ? {root[22:0], 1'b1} : {root[22:0], 1'b0});
              cy <= CW'(signed'(v.x)) <<< 8;
              state <= S_PRE;
            end
          end
        end
        S_PRE: begin
          if (mag > max_mag) max_mag <= mag;
          cnt <= '0;
          state <= S_ROT;
          if (cx < 0) begin
            if (cy >= 0) begin
              cx <= cy; cy <= -cx; cz <= CW'(90) <<< ANGLE_SCALE_BITS;
            end else begin
              cx <= -cy; cy <= cx; cz <= -(CW'(90) <<< ANGLE_SCALE_BITS);
            end
          end else begin
            cz <= '0;
          end
          if (cx == 0 && cy == 0) begin
            cz <= '0;
            state <= S_FIN;
          end
        end
        S_ROT: begin
          if (cy > 0) begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + CW'(atan_entry(ci));
          end else begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - CW'(atan_entry(ci));
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(CORDIC_STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          if (!angle) begin
            pitch_angle <= (rnd > lim) ? 14'(lim) : (rnd < -lim) ? 14'(-lim) : 14'(rnd);
            angle <= 1'b1;
            cx <= CW'(signed'(v.z)) <<< 8;
            cy <= -(CW'(signed'(v.y)) <<< 8);
            state <= S_PRE;
          end else begin
            roll_angle <= (rnd > lim) ? 15'(lim) : (rnd < -lim) ? 15'(-lim) : 15'(rnd);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_peak_mono: assert property (@(posedge clk) disable iff (rst)
    max_mag >= $past(max_mag) || $past(rst)) else $error("peak magnitude fell");
  a_peak_floor: assert property (@(posedge clk) disable iff (rst)
    !max_x[15] && !max_y[15] && !max_z[15]) else $error("axis peak negative");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(magnitude))
    else $error("result dropped");
`endif

endmodule

@@ rtl/accel_smooth_peak_tilt.sv @@
// ----------------------------------------------------------------------------
// accel_smooth_peak_tilt
// accelerometer smoothing, magnitude, peaks and pitch/roll
// ----------------------------------------------------------------------------
// each input transaction passes through the front, then the queue, then the back,
//   which gives the result transaction
// the rate of results is set by the back end, which takes no new vector while busy with its
//   two 24-step square roots and two 24-step cordic passes on one sequencer
// the queue lets the front smooth the next sample while the back is busy
// reset (rst, synchronous) clears history and peaks and restores the config registers to their defaults
module accel_smooth_peak_tilt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [16:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [asp_pkg::SAMPLE_WIDTH-1:0] sample_x,
  input  logic signed [asp_pkg::SAMPLE_WIDTH-1:0] sample_y,
  input  logic signed [asp_pkg::SAMPLE_WIDTH-1:0] sample_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      smooth_x,
  output logic signed [15:0]      smooth_y,
  output logic signed [15:0]      smooth_z,
  output logic [15:0]             magnitude,
  output logic [14:0]             peak_x,
  output logic [14:0]             peak_y,
  output logic [14:0]             peak_z,
  output logic [15:0]             peak_magnitude,
  output logic signed [13:0]      pitch_angle,
  output logic signed [14:0]      roll_angle
);
  import asp_pkg::*;

  // config registers, always writable
  logic        smooth_enable;
  logic [16:0] smooth_weight;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_enable <= 1'b0;
      smooth_weight <= 17'd52429;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SMOOTH_ENABLE: smooth_enable <= cfg_data[0];
        REG_SMOOTH_WEIGHT: smooth_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  vec_t f_vec, q_vec;
  logic f_valid, f_ready, q_valid, q_ready;

  // front: smoothing
  asp_front u_front (
    .clk, .rst, .smooth_enable, .smooth_weight,
    .in_valid, .in_ready,
    .in_x(sample_x), .in_y(sample_y), .in_z(sample_z),
    .out_valid(f_valid), .out_ready(f_ready), .out_vec(f_vec)
  );

  // decoupling queue
  asp_fifo u_fifo (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_vec),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_vec)
  );

  // back: magnitude, peaks, angles
  asp_back u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_vec(q_vec),
    .out_valid, .out_ready,
    .smooth_x, .smooth_y, .smooth_z, .magnitude,
    .peak_x, .peak_y, .peak_z, .peak_magnitude,
    .pitch_angle, .roll_angle
  );

endmodule
